FILE: rtl/tcwc_pkg.sv
`default_nettype none
package tcwc_pkg;

    localparam int NODES    = 65536;
    localparam int ALPHABET = 26;
    localparam int MAX_LEN  = 32;

    localparam int NODE_W  = $clog2(NODES);
    localparam int SYM_W   = 5;
    localparam int LEN_W   = $clog2(MAX_LEN + 2);
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int USED_W  = $clog2(NODES + 1);
    localparam int LADDR_W = NODE_W + SYM_W;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_TEST   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] letter;
        logic             last;
    } item_t;

    typedef struct packed {
        logic       is_compound;
        logic [1:0] status;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/tcwc_ram.sv
`default_nettype none
module tcwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/trie_compound_word_checker.sv
`default_nettype none
// Trie of up to NODES nodes with 26 links each, held in a 2M x 16 link RAM
// (row = node, column = letter) and a 64K x 1 word-end RAM. Insert and test
// words arrive one letter per beat and may interleave. After reset a clearing
// pass zeroes the root row before the first beat is taken. An insert letter
// whose link exists passes S_INS_CHK and S_INS_FIN; when a node is allocated
// it also passes S_INS_CLR and S_INS_LINK, since the new row is cleared one
// link per cycle through the single RAM write port. A test letter that is not
// last is only buffered; the last letter of a test word of 2 to MAX_LEN letters
// runs a sequencer that walks the trie one link read at a time. One result beat
// per last letter; the next beat is taken once the result has been accepted.
module trie_compound_word_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire tcwc_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output tcwc_pkg::result_t      result
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INS_CHK, S_INS_CLR, S_INS_LINK, S_INS_FIN,
        S_P_RD, S_P_CHK, S_P_MK, S_S_RD, S_S_CHK, S_S_MK
    } state_t;

    state_t                           state_reg, state_next;
    logic [tcwc_pkg::SYM_W-1:0]       cnt_reg, cnt_next;
    logic [tcwc_pkg::NODE_W-1:0]      cursor_reg, cursor_next;
    logic [tcwc_pkg::NODE_W-1:0]      new_reg, new_next;
    logic [tcwc_pkg::USED_W-1:0]      used_reg, used_next;
    logic                             ovf_reg, ovf_next;
    logic [tcwc_pkg::SYM_W-1:0]       sym_reg, sym_next;
    logic                             last_reg, last_next;
    logic [tcwc_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [tcwc_pkg::LEN_W-1:0]       wlen_reg, wlen_next;
    logic [tcwc_pkg::POS_W-1:0]       pi_reg, pi_next;
    logic [tcwc_pkg::POS_W-1:0]       k_reg, k_next;
    logic [tcwc_pkg::NODE_W-1:0]      np_reg, np_next;
    logic [tcwc_pkg::NODE_W-1:0]      ns_reg, ns_next;
    logic                             rv_reg, rv_next;
    tcwc_pkg::result_t                res_reg, res_next;

    logic [tcwc_pkg::SYM_W-1:0]       buf_reg [tcwc_pkg::MAX_LEN];
    logic [tcwc_pkg::POS_W-1:0]       buf_idx;
    logic [tcwc_pkg::SYM_W-1:0]       buf_sym;

    logic                             lnk_we;
    logic [tcwc_pkg::LADDR_W-1:0]     lnk_waddr, lnk_raddr;
    logic [tcwc_pkg::NODE_W-1:0]      lnk_wdata, lnk_rdata;
    logic                             mk_we, mk_wdata, mk_rdata;
    logic [tcwc_pkg::NODE_W-1:0]      mk_waddr, mk_raddr;

    logic                             accept;
    logic [tcwc_pkg::SYM_W-1:0]       sym_in;
    logic [tcwc_pkg::LEN_W-1:0]       len_new;
    logic                             buf_we;
    logic [tcwc_pkg::LEN_W:0]         pi_plus2;

    tcwc_ram #(.WIDTH(tcwc_pkg::NODE_W), .DEPTH(2 ** tcwc_pkg::LADDR_W)) u_links (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (lnk_raddr),
        .rdata (lnk_rdata)
    );

    tcwc_ram #(.WIDTH(1), .DEPTH(tcwc_pkg::NODES)) u_marks (
        .clk   (clk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    assign item_ready   = (state_reg == S_IDLE) && !rv_reg;
    assign accept       = item_valid && item_ready;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // saturate out-of-range letters
    assign sym_in = (item.letter >= tcwc_pkg::SYM_W'(tcwc_pkg::ALPHABET))
                  ? tcwc_pkg::SYM_W'(tcwc_pkg::ALPHABET - 1) : item.letter;

    // single read port on the test letter buffer
    assign buf_idx  = (state_reg == S_S_RD) ? k_reg : pi_reg;
    assign buf_sym  = buf_reg[buf_idx];
    assign pi_plus2 = (tcwc_pkg::LEN_W + 1)'(pi_reg) + (tcwc_pkg::LEN_W + 1)'(2);
    assign buf_we   = accept && (item.kind == tcwc_pkg::KIND_TEST)
                   && (len_reg < tcwc_pkg::LEN_W'(tcwc_pkg::MAX_LEN));
    assign len_new  = (len_reg < tcwc_pkg::LEN_W'(tcwc_pkg::MAX_LEN))
                    ? len_reg + 1'b1 : tcwc_pkg::LEN_W'(tcwc_pkg::MAX_LEN + 1);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cursor_next = cursor_reg;
        new_next    = new_reg;
        used_next   = used_reg;
        ovf_next    = ovf_reg;
        sym_next    = sym_reg;
        last_next   = last_reg;
        len_next    = len_reg;
        wlen_next   = wlen_reg;
        pi_next     = pi_reg;
        k_next      = k_reg;
        np_next     = np_reg;
        ns_next     = ns_reg;
        rv_next     = rv_reg;
        res_next    = res_reg;
        lnk_we      = 1'b0;
        lnk_waddr   = {cursor_reg, sym_reg};
        lnk_wdata   = new_reg;
        lnk_raddr   = {cursor_reg, sym_in};
        mk_we       = 1'b0;
        mk_waddr    = cursor_reg;
        mk_wdata    = 1'b0;
        mk_raddr    = lnk_rdata;

        if (rv_reg && result_ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                // clear the root row and its word-end mark
                lnk_we    = 1'b1;
                lnk_waddr = {tcwc_pkg::NODE_W'(0), cnt_reg};
                lnk_wdata = '0;
                mk_we     = 1'b1;
                mk_waddr  = '0;
                mk_wdata  = 1'b0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == tcwc_pkg::SYM_W'(tcwc_pkg::ALPHABET - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_next  = sym_in;
                    last_next = item.last;
                    if (item.kind == tcwc_pkg::KIND_INSERT)
                    begin
                        if (!ovf_reg)
                        begin
                            state_next = S_INS_CHK;
                        end
                        else if (item.last)
                        begin
                            rv_next              = 1'b1;
                            res_next.is_compound = 1'b0;
                            res_next.status      = tcwc_pkg::ST_POOL_FULL;
                            cursor_next          = '0;
                            ovf_next             = 1'b0;
                        end
                    end
                    else
                    begin
                        len_next = len_new;
                        if (item.last)
                        begin
                            len_next  = '0;
                            wlen_next = len_new;
                            if (len_new > tcwc_pkg::LEN_W'(tcwc_pkg::MAX_LEN))
                            begin
                                rv_next              = 1'b1;
                                res_next.is_compound = 1'b0;
                                res_next.status      = tcwc_pkg::ST_TOO_LONG;
                            end
                            else if (len_new < tcwc_pkg::LEN_W'(2))
                            begin
                                rv_next              = 1'b1;
                                res_next.is_compound = 1'b0;
                                res_next.status      = tcwc_pkg::ST_OK;
                            end
                            else
                            begin
                                pi_next    = '0;
                                np_next    = '0;
                                ns_next    = '0;
                                state_next = S_P_RD;
                            end
                        end
                    end
                end
            end
            S_INS_CHK:
            begin
                // follow the link or start an allocation
                if (lnk_rdata != '0)
                begin
                    cursor_next = lnk_rdata;
                    state_next  = S_INS_FIN;
                end
                else if (used_reg < tcwc_pkg::USED_W'(tcwc_pkg::NODES))
                begin
                    new_next   = used_reg[tcwc_pkg::NODE_W-1:0];
                    used_next  = used_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = S_INS_CLR;
                end
                else
                begin
                    ovf_next   = 1'b1;
                    state_next = S_INS_FIN;
                end
            end
            S_INS_CLR:
            begin
                // clear the new row one link per cycle
                lnk_we    = 1'b1;
                lnk_waddr = {new_reg, cnt_reg};
                lnk_wdata = '0;
                mk_we     = 1'b1;
                mk_waddr  = new_reg;
                mk_wdata  = 1'b0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == tcwc_pkg::SYM_W'(tcwc_pkg::ALPHABET - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_INS_LINK;
                end
            end
            S_INS_LINK:
            begin
                lnk_we      = 1'b1;
                lnk_waddr   = {cursor_reg, sym_reg};
                lnk_wdata   = new_reg;
                cursor_next = new_reg;
                state_next  = S_INS_FIN;
            end
            S_INS_FIN:
            begin
                state_next = S_IDLE;
                if (last_reg)
                begin
                    rv_next              = 1'b1;
                    res_next.is_compound = 1'b0;
                    if (ovf_reg)
                    begin
                        res_next.status = tcwc_pkg::ST_POOL_FULL;
                    end
                    else
                    begin
                        mk_we           = 1'b1;
                        mk_waddr        = cursor_reg;
                        mk_wdata        = 1'b1;
                        res_next.status = tcwc_pkg::ST_OK;
                    end
                    cursor_next = '0;
                    ovf_next    = 1'b0;
                end
            end
            S_P_RD:
            begin
                lnk_raddr  = {np_reg, buf_sym};
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                // prefix step; missing link ends the search
                mk_raddr = lnk_rdata;
                if (lnk_rdata == '0)
                begin
                    rv_next              = 1'b1;
                    res_next.is_compound = 1'b0;
                    res_next.status      = tcwc_pkg::ST_OK;
                    state_next           = S_IDLE;
                end
                else
                begin
                    np_next    = lnk_rdata;
                    state_next = S_P_MK;
                end
            end
            S_P_MK:
            begin
                if (mk_rdata)
                begin
                    ns_next    = '0;
                    k_next     = pi_reg + 1'b1;
                    state_next = S_S_RD;
                end
                else
                begin
                    state_next = S_S_MK;
                end
            end
            S_S_RD:
            begin
                lnk_raddr  = {ns_reg, buf_sym};
                state_next = S_S_CHK;
            end
            S_S_CHK:
            begin
                // suffix step
                mk_raddr = lnk_rdata;
                if (lnk_rdata == '0)
                begin
                    state_next = S_S_MK;
                end
                else if ((tcwc_pkg::LEN_W'(k_reg) + 1'b1) < wlen_reg)
                begin
                    ns_next    = lnk_rdata;
                    k_next     = k_reg + 1'b1;
                    state_next = S_S_RD;
                end
                else
                begin
                    ns_next    = lnk_rdata;
                    k_next     = '0;
                    state_next = S_S_MK;
                end
            end
            S_S_MK:
            begin
                // with ns nonzero, k is zero only when the suffix walk reached its end
                if ((ns_next != '0) && (k_reg == '0) && (ns_reg != '0) && mk_rdata)
                begin
                    rv_next              = 1'b1;
                    res_next.is_compound = 1'b1;
                    res_next.status      = tcwc_pkg::ST_OK;
                    state_next           = S_IDLE;
                end
                else if (pi_plus2 < (tcwc_pkg::LEN_W + 1)'(wlen_reg))
                begin
                    pi_next    = pi_reg + 1'b1;
                    ns_next    = '0;
                    state_next = S_P_RD;
                end
                else
                begin
                    rv_next              = 1'b1;
                    res_next.is_compound = 1'b0;
                    res_next.status      = tcwc_pkg::ST_OK;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cnt_reg    <= '0;
            cursor_reg <= '0;
            new_reg    <= '0;
            used_reg   <= tcwc_pkg::USED_W'(1);
            ovf_reg    <= 1'b0;
            sym_reg    <= '0;
            last_reg   <= 1'b0;
            len_reg    <= '0;
            wlen_reg   <= '0;
            pi_reg     <= '0;
            k_reg      <= '0;
            np_reg     <= '0;
            ns_reg     <= '0;
            rv_reg     <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cursor_reg <= cursor_next;
            new_reg    <= new_next;
            used_reg   <= used_next;
            ovf_reg    <= ovf_next;
            sym_reg    <= sym_next;
            last_reg   <= last_next;
            len_reg    <= len_next;
            wlen_reg   <= wlen_next;
            pi_reg     <= pi_next;
            k_reg      <= k_next;
            np_reg     <= np_next;
            ns_reg     <= ns_next;
            rv_reg     <= rv_next;
            res_reg    <= res_next;
        end
    end

    // test letter buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[len_reg[tcwc_pkg::POS_W-1:0]] <= sym_in;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tcwc_checker.sv
`default_nettype none
module tcwc_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire tcwc_pkg::item_t   item,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire tcwc_pkg::result_t result
);

    // pending result beat holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    // no new item taken while a result waits
    a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("item taken while result pending");

    // status code stays in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status != 2'd3)
        else $error("bad status code");

    // error results never claim a compound word
    a_err_not_compound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != tcwc_pkg::ST_OK |-> !result.is_compound)
        else $error("compound flag on error result");

    // a result does not rise right after an idle cycle with no beat offered, unless item.last was high
    a_result_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready && !item_valid, 1) || $past(item.last, 1)
            || !$past(item_ready, 1))
        else $error("result without an input beat");

endmodule

bind trie_compound_word_checker tcwc_checker u_tcwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire
